// ===== hw/rtl/dtes_pkg.sv =====
// package: transaction types, constants and calendar tables for the epoch converter
`timescale 1ns / 1ps

package dtes_pkg;

    typedef struct packed {
        logic [39:0] year_in;
        logic [3:0]  month_in;
        logic [4:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
    } t_date_in;

    typedef struct packed {
        logic [63:0] epoch_seconds;
        logic        date_valid;
    } t_epoch_out;

    localparam int K_STAGES = 8;

    localparam logic [39:0] K_MAX_YEAR        = 40'd584554049253;
    localparam logic [24:0] K_SECS_PER_YEAR   = 25'd31536000;
    localparam logic [16:0] K_SECS_PER_DAY    = 17'd86400;
    localparam logic [16:0] K_SECS_PER_HOUR   = 17'd3600;
    localparam logic [16:0] K_SECS_PER_MINUTE = 17'd60;

    // exact reciprocals of 25 for 19-bit and 24-bit dividends
    localparam logic [19:0] K_RCP_HI   = 20'd671089;
    localparam logic [24:0] K_RCP_LO   = 25'd21474837;
    localparam int          K_RCP_HI_SHIFT = 24;
    localparam int          K_RCP_LO_SHIFT = 29;
    localparam logic [4:0]  K_DIV      = 5'd25;

    localparam logic [3:0] K_MONTH_JAN = 4'd1;
    localparam logic [3:0] K_MONTH_FEB = 4'd2;
    localparam logic [3:0] K_MONTH_DEC = 4'd12;

    localparam logic [4:0] K_MAX_HOUR     = 5'd24;
    localparam logic [5:0] K_MAX_MINUTE   = 6'd60;
    localparam logic [5:0] K_MAX_SECOND   = 6'd60;
    localparam logic [4:0] K_FEB_LEAP_LEN = 5'd29;

    function automatic logic [8:0] f_days_before(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/dtes_date_check.sv =====
// month length check and day-of-year offset for one date
`timescale 1ns / 1ps

module dtes_date_check (
    input  logic [3:0] i_month,
    input  logic [4:0] i_day,
    input  logic       i_leap,
    output logic       o_day_ok,
    output logic [8:0] o_day_offset
);
    import dtes_pkg::*;

    logic [4:0] w_limit;
    logic       w_leap_adj;

    always_comb begin
        w_limit = f_month_len(i_month);
        if (i_leap && (i_month == K_MONTH_FEB)) begin
            w_limit = K_FEB_LEAP_LEN;
        end
        w_leap_adj   = i_leap && (i_month > K_MONTH_FEB);
        o_day_ok     = (i_day <= w_limit);
        o_day_offset = f_days_before(i_month) + 9'(w_leap_adj) + 9'(i_day) - 9'd1;
    end

endmodule

// ===== hw/rtl/date_time_to_epoch_seconds.sv =====
// top level: pipelined calendar date and time to seconds since year zero
// an accepted transaction is registered in turn through stages 1 to 8 on its way to o_data
// throughput: one transaction per cycle while the output is not stalled, set by the 8-stage pipeline
// an output stall holds the last stage; empty stages keep filling behind it
// reset clears all stage valid bits; payload registers are not reset
`timescale 1ns / 1ps

module date_time_to_epoch_seconds (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  dtes_pkg::t_date_in    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output dtes_pkg::t_epoch_out  o_data
);
    import dtes_pkg::*;

    logic [K_STAGES-1:0] r_v;
    logic [K_STAGES-1:0] w_en;

    // stage 1
    logic [39:0] r_s1_year;
    logic [3:0]  r_s1_month;
    logic [4:0]  r_s1_day;
    logic [16:0] r_s1_tsec;
    logic        r_s1_ok;
    logic [38:0] r_s1_ph;
    logic [44:0] r_s1_yph;
    logic [44:0] r_s1_ypl;
    // stage 2
    logic [39:0] r_s2_year;
    logic [3:0]  r_s2_month;
    logic [4:0]  r_s2_day;
    logic [16:0] r_s2_tsec;
    logic        r_s2_ok;
    logic [14:0] r_s2_qh;
    logic [23:0] r_s2_t;
    logic [63:0] r_s2_base;
    // stage 3
    logic [39:0] r_s3_year;
    logic [3:0]  r_s3_month;
    logic [4:0]  r_s3_day;
    logic [16:0] r_s3_tsec;
    logic        r_s3_ok;
    logic [14:0] r_s3_qh;
    logic [23:0] r_s3_t;
    logic [48:0] r_s3_pl;
    logic [63:0] r_s3_base;
    // stage 4
    logic [39:0] r_s4_year;
    logic [3:0]  r_s4_month;
    logic [4:0]  r_s4_day;
    logic [16:0] r_s4_tsec;
    logic        r_s4_ok;
    logic [33:0] r_s4_q25;
    logic [4:0]  r_s4_r25;
    logic [63:0] r_s4_base;
    // stage 5
    logic [37:0] r_s5_lb;
    logic [8:0]  r_s5_dofs;
    logic [16:0] r_s5_tsec;
    logic        r_s5_ok;
    logic [63:0] r_s5_base;
    // stage 6
    logic [37:0] r_s6_days;
    logic        r_s6_ok;
    logic [63:0] r_s6_base;
    // stage 7
    logic [54:0] r_s7_dsec;
    logic        r_s7_ok;
    logic [63:0] r_s7_base;
    // stage 8
    t_epoch_out  r_s8_out;

    // stage 1 logic
    logic        n_s1_ok;
    logic [16:0] n_s1_tsec;
    // stage 2 logic
    logic [14:0] n_s2_qh;
    logic [19:0] n_s2_qh25;
    logic [19:0] n_s2_rh;
    // stage 4 logic
    logic [18:0] n_s4_ql;
    logic [23:0] n_s4_ql25;
    logic [23:0] n_s4_rl;
    // stage 5 logic
    logic        n_s5_m4;
    logic        n_s5_m100;
    logic        n_s5_m400;
    logic        n_s5_leap;
    logic [38:0] n_s5_c4;
    logic [38:0] n_s5_c100;
    logic [38:0] n_s5_c400;
    logic [38:0] n_s5_lb;
    logic        n_s5_day_ok;
    logic [8:0]  n_s5_dofs;
    // stage 8 logic
    logic [63:0] n_s8_sum;

    // stage enables: a stage loads when empty or when the one after it moves
    always_comb begin
        w_en[K_STAGES-1] = !r_v[K_STAGES-1] || !i_stall;
        for (int k = K_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[K_STAGES-1];
    assign o_data  = r_s8_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < K_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: range checks, time of day, high reciprocal product, year products
    always_comb begin
        n_s1_ok = (i_data.year_in <= K_MAX_YEAR) &&
                  (i_data.month_in >= K_MONTH_JAN) && (i_data.month_in <= K_MONTH_DEC) &&
                  (i_data.day_in != 5'd0) && (i_data.hour_in <= K_MAX_HOUR) &&
                  (i_data.minute_in <= K_MAX_MINUTE) && (i_data.second_in <= K_MAX_SECOND);
        n_s1_tsec = 17'(i_data.hour_in) * K_SECS_PER_HOUR +
                    17'(i_data.minute_in) * K_SECS_PER_MINUTE +
                    17'(i_data.second_in);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_year  <= i_data.year_in;
            r_s1_month <= i_data.month_in;
            r_s1_day   <= i_data.day_in;
            r_s1_tsec  <= n_s1_tsec;
            r_s1_ok    <= n_s1_ok;
            r_s1_ph    <= 39'(i_data.year_in[39:21]) * 39'(K_RCP_HI);
            r_s1_yph   <= 45'(i_data.year_in[39:20]) * 45'(K_SECS_PER_YEAR);
            r_s1_ypl   <= 45'(i_data.year_in[19:0]) * 45'(K_SECS_PER_YEAR);
        end
    end

    // stage 2: high quotient and remainder of year/4 by 25, year seconds sum
    always_comb begin
        n_s2_qh   = r_s1_ph[K_RCP_HI_SHIFT+14:K_RCP_HI_SHIFT];
        n_s2_qh25 = 20'(n_s2_qh) * 20'(K_DIV);
        n_s2_rh   = 20'(r_s1_year[39:21]) - n_s2_qh25;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_year  <= r_s1_year;
            r_s2_month <= r_s1_month;
            r_s2_day   <= r_s1_day;
            r_s2_tsec  <= r_s1_tsec;
            r_s2_ok    <= r_s1_ok;
            r_s2_qh    <= n_s2_qh;
            r_s2_t     <= {n_s2_rh[4:0], r_s1_year[20:2]};
            r_s2_base  <= 64'({r_s1_yph, 20'd0}) + 64'(r_s1_ypl);
        end
    end

    // stage 3: low reciprocal product
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_year  <= r_s2_year;
            r_s3_month <= r_s2_month;
            r_s3_day   <= r_s2_day;
            r_s3_tsec  <= r_s2_tsec;
            r_s3_ok    <= r_s2_ok;
            r_s3_qh    <= r_s2_qh;
            r_s3_t     <= r_s2_t;
            r_s3_pl    <= 49'(r_s2_t) * 49'(K_RCP_LO);
            r_s3_base  <= r_s2_base;
        end
    end

    // stage 4: floor(year/100) and the remainder of year/4 by 25
    always_comb begin
        n_s4_ql   = r_s3_pl[K_RCP_LO_SHIFT+18:K_RCP_LO_SHIFT];
        n_s4_ql25 = 24'(n_s4_ql) * 24'(K_DIV);
        n_s4_rl   = r_s3_t - n_s4_ql25;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_year  <= r_s3_year;
            r_s4_month <= r_s3_month;
            r_s4_day   <= r_s3_day;
            r_s4_tsec  <= r_s3_tsec;
            r_s4_ok    <= r_s3_ok;
            r_s4_q25   <= {r_s3_qh, n_s4_ql};
            r_s4_r25   <= n_s4_rl[4:0];
            r_s4_base  <= r_s3_base;
        end
    end

    // stage 5: leap rule, leap days before the year, month length check, day-of-year offset
    always_comb begin
        n_s5_m4   = (r_s4_year[1:0] == 2'd0);
        n_s5_m100 = n_s5_m4 && (r_s4_r25 == 5'd0);
        n_s5_m400 = n_s5_m100 && (r_s4_q25[1:0] == 2'd0);
        n_s5_leap = n_s5_m4 && (!n_s5_m100 || n_s5_m400);
        n_s5_c4   = 39'(r_s4_year[39:2]) + 39'(r_s4_year[1:0] != 2'd0);
        n_s5_c100 = 39'(r_s4_q25) + 39'(!n_s5_m100);
        n_s5_c400 = 39'(r_s4_q25[33:2]) + 39'(!n_s5_m400);
        n_s5_lb   = n_s5_c4 - n_s5_c100 + n_s5_c400;
    end

    dtes_date_check u_date_check (
        .i_month      (r_s4_month),
        .i_day        (r_s4_day),
        .i_leap       (n_s5_leap),
        .o_day_ok     (n_s5_day_ok),
        .o_day_offset (n_s5_dofs)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_lb   <= n_s5_lb[37:0];
            r_s5_dofs <= n_s5_dofs;
            r_s5_tsec <= r_s4_tsec;
            r_s5_ok   <= r_s4_ok && n_s5_day_ok;
            r_s5_base <= r_s4_base;
        end
    end

    // stage 6: day count and year plus time of day
    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_days <= r_s5_lb + 38'(r_s5_dofs);
            r_s6_ok   <= r_s5_ok;
            r_s6_base <= r_s5_base + 64'(r_s5_tsec);
        end
    end

    // stage 7: days to seconds
    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s7_dsec <= 55'(r_s6_days) * 55'(K_SECS_PER_DAY);
            r_s7_ok   <= r_s6_ok;
            r_s7_base <= r_s6_base;
        end
    end

    // stage 8: final sum, zero on failed checks
    assign n_s8_sum = r_s7_base + 64'(r_s7_dsec);

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s8_out.epoch_seconds <= r_s7_ok ? n_s8_sum : 64'd0;
            r_s8_out.date_valid    <= r_s7_ok;
        end
    end

endmodule

// ===== hw/rtl/dtes_sva.sv =====
// port-level assertions for the epoch converter and their bind
`timescale 1ns / 1ps

module dtes_sva (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input dtes_pkg::t_date_in    i_data,
    input logic                  o_valid,
    input logic                  i_stall,
    input dtes_pkg::t_epoch_out  o_data
);
    import dtes_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // input side only backs up when the pipe is full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output can drain");

    // a failed check always reports zero seconds
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.date_valid) |-> (o_data.epoch_seconds == 64'd0))
        else $error("invalid date with nonzero seconds");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind date_time_to_epoch_seconds dtes_sva u_dtes_sva (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== sim/epoch_checker.sv =====
// checker: predicts the epoch seconds of every accepted date and compares the results
`timescale 1ns / 1ps

module epoch_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  dtes_pkg::t_date_in   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  dtes_pkg::t_epoch_out i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import dtes_pkg::*;

    t_epoch_out epochs_due[$];
    int         fail_cnt = 0;

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        if (m == K_MONTH_FEB) begin
            return leap ? K_FEB_LEAP_LEN : 5'd28;
        end
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            return 5'd30;
        end
        return 5'd31;
    endfunction

    function automatic t_epoch_out calc_epoch(input t_date_in d);
        t_epoch_out  r;
        logic [63:0] yr;
        logic [63:0] days;
        logic        leap;
        r    = '0;
        yr   = 64'(d.year_in);
        leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        if (d.year_in > K_MAX_YEAR || d.month_in < K_MONTH_JAN || d.month_in > K_MONTH_DEC
            || d.day_in == 5'd0 || d.hour_in > K_MAX_HOUR || d.minute_in > K_MAX_MINUTE
            || d.second_in > K_MAX_SECOND) begin
            return r;
        end
        if (d.day_in > month_days(d.month_in, leap)) begin
            return r;
        end
        // leap days of years 0 .. year-1
        days = (yr + 64'd3) / 64'd4 - (yr + 64'd99) / 64'd100 + (yr + 64'd399) / 64'd400;
        for (int m = 1; m < int'(d.month_in); m++) begin
            days = days + 64'(month_days(4'(m), leap));
        end
        days = days + 64'(d.day_in) - 64'd1;
        r.epoch_seconds = yr * 64'd31536000 + days * 64'd86400
                        + 64'(d.hour_in) * 64'd3600 + 64'(d.minute_in) * 64'd60
                        + 64'(d.second_in);
        r.date_valid = 1'b1;
        return r;
    endfunction

    task automatic note_fail(input string msg);
        if (fail_cnt < 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        fail_cnt = fail_cnt + 1;
    endtask

    always @(posedge i_clk) begin : compare_p
        t_epoch_out want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                epochs_due.push_back(calc_epoch(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                if (epochs_due.size() == 0) begin
                    note_fail($sformatf("unexpected transaction %0d/%0b",
                                        i_out_data.epoch_seconds, i_out_data.date_valid));
                end else begin
                    want = epochs_due.pop_front();
                    if (i_out_data.epoch_seconds !== want.epoch_seconds) begin
                        note_fail($sformatf("epoch_seconds expected %0d got %0d",
                                            want.epoch_seconds, i_out_data.epoch_seconds));
                    end
                    if (i_out_data.date_valid !== want.date_valid) begin
                        note_fail($sformatf("date_valid expected %0b got %0b",
                                            want.date_valid, i_out_data.date_valid));
                    end
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= epochs_due.size();
    end

endmodule

// ===== sim/tb.sv =====
// testbench top: drives dates into the epoch converter and gives the verdict
`timescale 1ns / 1ps

module tb;
    import dtes_pkg::*;

    localparam int RANDOM_ITEMS = 1330;
    localparam int CYCLE_LIMIT  = 200000;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_stall = 1'b0;
    t_date_in    in_data   = '0;
    logic        in_stall;
    logic        out_valid;
    t_epoch_out  out_data;
    int          fail_count;
    int          pending_count;
    int unsigned cycle_cnt = 0;
    int unsigned hold_cnt  = 0;
    logic        calm_tx   = 1'b0;
    logic        calm_rx   = 1'b0;

    date_time_to_epoch_seconds dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    epoch_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver holds off for a random count after each transaction
    always @(posedge i_clk) begin
        if (out_valid && !out_stall) begin
            hold_cnt = calm_rx ? 0 : $urandom_range(6, 0);
        end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
        end
        out_stall <= (hold_cnt != 0);
    end

    function automatic t_date_in mk_date(input logic [39:0] y, input logic [3:0] m,
                                         input logic [4:0] d, input logic [4:0] h,
                                         input logic [5:0] mi, input logic [5:0] s);
        t_date_in r;
        r.year_in   = y;
        r.month_in  = m;
        r.day_in    = d;
        r.hour_in   = h;
        r.minute_in = mi;
        r.second_in = s;
        return r;
    endfunction

    function automatic logic [39:0] pick_year();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        case ($urandom_range(4, 0))
            0: return 40'($urandom_range(9999, 0));
            1: return 40'($urandom_range(6000, 1) * 100) + 40'($urandom_range(2, 0)) - 40'd1;
            2: return 40'(wide % (64'(K_MAX_YEAR) + 64'd1));
            3: return K_MAX_YEAR - 40'($urandom_range(2000, 0));
            default: return 40'($urandom_range(2000000, 0));
        endcase
    endfunction

    function automatic t_date_in pick_date();
        t_date_in d;
        if ($urandom_range(6, 0) == 0) begin
            d.year_in   = 40'({$urandom, $urandom});
            d.month_in  = 4'($urandom);
            d.day_in    = 5'($urandom);
            d.hour_in   = 5'($urandom);
            d.minute_in = 6'($urandom);
            d.second_in = 6'($urandom);
            return d;
        end
        d.year_in   = pick_year();
        d.month_in  = 4'($urandom_range(12, 1));
        d.day_in    = ($urandom_range(3, 0) == 0) ? 5'($urandom_range(31, 29))
                                                  : 5'($urandom_range(28, 1));
        d.hour_in   = ($urandom_range(7, 0) == 0) ? K_MAX_HOUR : 5'($urandom_range(23, 0));
        d.minute_in = ($urandom_range(7, 0) == 0) ? K_MAX_MINUTE : 6'($urandom_range(59, 0));
        d.second_in = ($urandom_range(7, 0) == 0) ? K_MAX_SECOND : 6'($urandom_range(59, 0));
        // break one field now and then
        if ($urandom_range(9, 0) == 0) begin
            case ($urandom_range(4, 0))
                0: d.month_in  = ($urandom_range(1, 0) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
                1: d.day_in    = 5'd0;
                2: d.hour_in   = 5'($urandom_range(31, 25));
                3: d.minute_in = 6'($urandom_range(63, 61));
                default: d.second_in = 6'($urandom_range(63, 61));
            endcase
        end
        return d;
    endfunction

    task automatic push_date(input t_date_in d);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(6, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge i_clk); while (in_stall);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_date(mk_date(40'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(K_MAX_YEAR, 4'd12, 5'd31, 5'd24, 6'd60, 6'd60));
        push_date(mk_date(K_MAX_YEAR + 40'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'hFF_FFFF_FFFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
        push_date(mk_date(40'd2024, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2024, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2024, 4'd15, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2024, 4'd5, 5'd0, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2000, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30));
        push_date(mk_date(40'd1900, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2100, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2024, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59));
        push_date(mk_date(40'd2023, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2023, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd2024, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd400, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd0, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0));
        push_date(mk_date(40'd1999, 4'd12, 5'd31, 5'd24, 6'd60, 6'd60));
        push_date(mk_date(40'd1970, 4'd1, 5'd1, 5'd25, 6'd0, 6'd0));
        push_date(mk_date(40'd1970, 4'd1, 5'd1, 5'd31, 6'd0, 6'd0));
        push_date(mk_date(40'd1970, 4'd1, 5'd1, 5'd0, 6'd61, 6'd0));
        push_date(mk_date(40'd1970, 4'd1, 5'd1, 5'd0, 6'd63, 6'd0));
        push_date(mk_date(40'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd61));
        push_date(mk_date(40'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd63));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 150 == 0) begin
                calm_tx <= ($urandom_range(3, 0) == 0);
                calm_rx <= ($urandom_range(3, 0) == 0);
            end
            push_date(pick_date());
        end
        in_valid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (2 * K_STAGES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dtes_pkg.sv
hw/rtl/dtes_date_check.sv
hw/rtl/date_time_to_epoch_seconds.sv
hw/rtl/dtes_sva.sv
sim/epoch_checker.sv
sim/tb.sv
